/* design/prast_pkg.sv */
// Shared constants for the perturbed Rastrigin evaluator.
package prast_pkg;
	localparam int FRAC_BITS = 12;
	localparam int SIN_LAT = 5;
	localparam logic [14:0] Q14_ONE = 15'd16384;
	localparam logic [14:0] POLY_A = 15'd25736;
	localparam logic [13:0] POLY_B = 14'd10512;
	localparam logic [10:0] POLY_C = 11'd1160;
	localparam logic [11:0] QTURN = 12'd1024;
	localparam longint TWENTY_PI_Q14 = 1029437;
	localparam longint PI_Q14 = 51472;
	localparam longint TEN_Q14 = 163840;
	// ceil(2^24 / 5), exact for dividends below 2^22.
	localparam logic [21:0] RECIP5 = 22'd3355444;
	localparam int GRAD_MAX = 926000;
endpackage

/* design/prast_sine.sv */
// Five-stage fixed-point sine cell: phase in turns to a Q14 sine.
module prast_sine (
	input  logic               clk,
	input  logic               en,
	input  logic [11:0]        phase,
	output logic signed [15:0] sin_val
);
	import prast_pkg::*;

	logic [14:0] t_raw, t_sel;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [14:0] t_s1, t_s2, t_s3, t_s4;
	logic [14:0] t2_s2, t2_s3;
	logic [13:0] in1_s3, m_s4;
	logic [29:0] sq, mp, sp;
	logic [25:0] cp;
	logic [15:0] s_abs, s_clip;

	assign t_raw = {1'b0, phase[9:0], 4'b0000};
	assign t_sel = phase[10] ? (Q14_ONE - t_raw) : t_raw;
	assign sq = 30'(t_s1) * 30'(t_s1);
	assign cp = 26'(POLY_C) * 26'(t2_s2);
	assign mp = 30'(t2_s3) * 30'(in1_s3);
	assign sp = 30'(t_s4) * 30'(POLY_A - 15'(m_s4));
	assign s_abs = 16'(sp >> 14);
	assign s_clip = (s_abs > 16'(Q14_ONE)) ? 16'(Q14_ONE) : s_abs;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_sel;
			neg_s1 <= phase[11];
			t2_s2 <= 15'(sq >> 14);
			t_s2 <= t_s1;
			neg_s2 <= neg_s1;
			in1_s3 <= POLY_B - 14'(cp >> 14);
			t2_s3 <= t2_s2;
			t_s3 <= t_s2;
			neg_s3 <= neg_s2;
			m_s4 <= 14'(mp >> 14);
			t_s4 <= t_s3;
			neg_s4 <= neg_s3;
			sin_val <= neg_s4 ? -$signed(s_clip) : $signed(s_clip);
		end
	end
endmodule

/* design/perturbed_rastrigin_eval_top.sv */
// Top level of the perturbed Rastrigin evaluator: sine cells, product stages, accumulator.
// An accepted item passes through the sine cells, then stages 6, 7 and 8, and its result is
// then loaded into the output register, which raises out_valid for the output handshake.
// Throughput is one item per cycle; the whole pipeline holds only while a result waits.
// The depth is set by the five-stage sine cells, three product stages and the output register.
// Asynchronous active-low reset clears the stage valid bits and the running sum.
module perturbed_rastrigin_eval_top #(
	parameter int MAX_COORDS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] coord_value,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [20:0] grad_component,
	output logic [23:0]        objective_sum,
	output logic               sum_valid
);
	import prast_pkg::*;

	// Saturation level of the objective: 51 per coordinate, capped at 24 bits.
	localparam longint SumRaw = longint'(MAX_COORDS) * 51 * (longint'(1) << FRAC_BITS);
	localparam logic [23:0] SUM_MAX = (SumRaw > 16777215) ? 24'hFFFFFF : 24'(SumRaw);

	// The pipeline moves as one whole whenever the output register can take a result.
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// Phases in turns: x, x plus a quarter, 5x, 5x plus a quarter.
	logic [11:0] ph1, ph1c, ph5, ph5c;
	assign ph1 = coord_value[11:0];
	assign ph1c = ph1 + QTURN;
	assign ph5 = 12'(coord_value) + 12'(coord_value <<< 2);
	assign ph5c = ph5 + QTURN;

	logic signed [15:0] sin2, cos2, sin10, cos10;
	prast_sine u_sin2  (.clk(clk), .en(en), .phase(ph1),  .sin_val(sin2));
	prast_sine u_cos2  (.clk(clk), .en(en), .phase(ph1c), .sin_val(cos2));
	prast_sine u_sin10 (.clk(clk), .en(en), .phase(ph5),  .sin_val(sin10));
	prast_sine u_cos10 (.clk(clk), .en(en), .phase(ph5c), .sin_val(cos10));

	// Side line that carries x, x squared and the last flag beside the sine cells.
	logic signed [15:0] x_line_q [SIN_LAT];
	logic [18:0]        x2_line_q [SIN_LAT];
	logic               last_line_q [SIN_LAT];
	logic [SIN_LAT-1:0] vld_line_q;
	logic [31:0]        xsq;
	assign xsq = 32'($signed(coord_value) * $signed(coord_value));

	always_ff @(posedge clk) begin
		if (en) begin
			x_line_q[0] <= coord_value;
			x2_line_q[0] <= xsq[30:12];
			last_line_q[0] <= is_last;
			for (int i = 1; i < SIN_LAT; i++) begin
				x_line_q[i] <= x_line_q[i-1];
				x2_line_q[i] <= x2_line_q[i-1];
				last_line_q[i] <= last_line_q[i-1];
			end
		end
	end

	// Stage 6: Rastrigin term, scale factor, sine part of the gradient and the cosine factor.
	logic signed [16:0] dcos;
	logic [19:0]        ten_dcos, z_c;
	logic signed [18:0] f10_c;
	logic signed [37:0] p_sin2;
	logic signed [20:0] t1_c;
	logic signed [33:0] p_cos10;
	assign dcos = 17'sd16384 - 17'(cos2);
	assign ten_dcos = 20'(dcos[15:0]) * 20'd10;
	assign z_c = 20'(x2_line_q[SIN_LAT-1]) + (ten_dcos >> 2);
	assign f10_c = 19'(TEN_Q14) + 19'(sin10);
	assign p_sin2 = 38'(sin2) * 38'(TWENTY_PI_Q14);
	assign t1_c = (21'(x_line_q[SIN_LAT-1]) <<< 1) + 21'(p_sin2 >>> 16);
	assign p_cos10 = 34'(cos10) * 34'(PI_Q14);

	logic [19:0]        z_s6;
	logic [17:0]        f10_s6;
	logic [19:0]        t1m_s6;
	logic               t1n_s6, last_s6;
	logic signed [16:0] pc_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s6 <= z_c;
			f10_s6 <= f10_c[17:0];
			t1n_s6 <= t1_c[20];
			t1m_s6 <= t1_c[20] ? 20'(-t1_c) : t1_c[19:0];
			pc_s6 <= 17'(p_cos10 >>> 14);
			last_s6 <= last_line_q[SIN_LAT-1];
		end
	end

	// Stage 7: the three products, each scaled down by a power of two.
	logic [37:0]        pz, ptf;
	logic signed [37:0] pcz;
	assign pz = 38'(z_s6) * 38'(f10_s6);
	assign ptf = 38'(t1m_s6) * 38'(f10_s6);
	assign pcz = 38'(pc_s6) * $signed({18'b0, z_s6});

	logic [20:0]        pz_s7, ptf_s7;
	logic signed [21:0] pcz_s7;
	logic               t1n_s7, last_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			pz_s7 <= 21'(pz >> 15);
			ptf_s7 <= 21'(ptf >> 15);
			pcz_s7 <= 22'(pcz >>> 14);
			t1n_s7 <= t1n_s6;
			last_s7 <= last_s6;
		end
	end

	// Stage 8: the remaining divide by five through a reciprocal multiply.
	logic [42:0]        qz_p, qg_p;
	logic [18:0]        qz, qg;
	logic signed [22:0] g_c;
	assign qz_p = 43'(pz_s7) * 43'(RECIP5);
	assign qg_p = 43'(ptf_s7) * 43'(RECIP5);
	assign qz = 19'(qz_p >> 24);
	assign qg = 19'(qg_p >> 24);
	assign g_c = (t1n_s7 ? -$signed(23'(qg)) : $signed(23'(qg))) + 23'(pcz_s7);

	logic [18:0]        term_s8;
	logic signed [22:0] g_s8;
	logic               last_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			term_s8 <= qz;
			g_s8 <= g_c;
			last_s8 <= last_s7;
		end
	end

	// Output register: gradient clamp and the saturating running sum.
	logic [24:0]        sum_c;
	logic [23:0]        sum_sat;
	logic signed [20:0] g_sat;
	logic [23:0]        running_q;
	logic               vld_s6, vld_s7, vld_s8;
	assign sum_c = 25'(running_q) + 25'(term_s8);
	assign sum_sat = (sum_c > 25'(SUM_MAX)) ? SUM_MAX : sum_c[23:0];

	always_comb begin
		priority if (g_s8 > 23'(GRAD_MAX))
			g_sat = 21'(GRAD_MAX);
		else if (g_s8 < -23'(GRAD_MAX))
			g_sat = -21'(GRAD_MAX);
		else
			g_sat = g_s8[20:0];
	end

	always_ff @(posedge clk) begin
		if (en && vld_s8) begin
			grad_component <= g_sat;
			objective_sum <= last_s8 ? sum_sat : 24'd0;
			sum_valid <= last_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_line_q <= '0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			out_valid <= 1'b0;
			running_q <= '0;
		end else if (en) begin
			vld_line_q <= {vld_line_q[SIN_LAT-2:0], in_valid};
			vld_s6 <= vld_line_q[SIN_LAT-1];
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			out_valid <= vld_s8;
			if (vld_s8)
				running_q <= last_s8 ? 24'd0 : sum_sat;
		end
	end
endmodule

/* design/prast_checker.sv */
// Port-level checks for the perturbed Rastrigin evaluator, bound to the top level.
module prast_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [20:0] grad_component,
	input logic [23:0]        objective_sum,
	input logic               sum_valid
);
	import prast_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the pipeline is held");

	a_nosum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sum_valid |-> objective_sum == 24'd0)
		else $error("objective shown on a non-final item");

	a_grad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (grad_component <= 21'sd926000) && (grad_component >= -21'sd926000))
		else $error("gradient outside its clamp");
endmodule

bind perturbed_rastrigin_eval_top prast_port_checks u_prast_port_checks (.*);
